/* design/lfu_pkg.sv */
// Package for the LFU page replacement block: sizes, frame record, controller states.
// It has no dependencies. The interfaces and all design modules use it.
package lfu_pkg;

  localparam int FRAMES  = 8;
  localparam int PAGE_W  = 16;
  localparam int FREQ_W  = 16;
  localparam int STAMP_W = 32;
  localparam int FAULT_W = 32;
  localparam int SLOT_W  = 3;
  localparam int CFG_W   = 4;
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [FREQ_W-1:0]  freq;
    logic [STAMP_W-1:0] stamp;
  } frame_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MISS,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic step;
    logic first;
  } scan_ctl_t;

endpackage

/* design/lfu_in_if.sv */
// Access channel interface: valid/ready handshake with one page number.
// Depends on lfu_pkg for the payload width.
interface lfu_in_if;
  logic                      valid;
  logic                      ready;
  logic [lfu_pkg::PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

/* design/lfu_out_if.sv */
// Result channel interface: valid/ready handshake with the replacement outcome.
// Depends on lfu_pkg for the payload widths.
interface lfu_out_if;
  logic                        valid;
  logic                        ready;
  logic                        fault;
  logic [lfu_pkg::SLOT_W-1:0]  slot;
  logic                        evicted;
  logic [lfu_pkg::PAGE_W-1:0]  evicted_page;
  logic [lfu_pkg::FREQ_W-1:0]  use_count;
  logic [lfu_pkg::FAULT_W-1:0] fault_total;

  modport source (output valid, output fault, output slot, output evicted,
                  output evicted_page, output use_count, output fault_total,
                  input ready);
  modport sink   (input valid, input fault, input slot, input evicted,
                  input evicted_page, input use_count, input fault_total,
                  output ready);
endinterface

/* design/lfu_victim.sv */
// Victim tracker: keeps the best replacement candidate seen during a frame scan.
// Depends on lfu_pkg for the frame record and the scan control struct.
module lfu_victim (
  input  logic                      clk,
  input  lfu_pkg::scan_ctl_t        ctl,
  input  logic [lfu_pkg::IDX_W-1:0] idx,
  input  lfu_pkg::frame_t           rd_frame,
  output logic [lfu_pkg::IDX_W-1:0] win_idx,
  output lfu_pkg::frame_t           win_frame
);
  import lfu_pkg::*;

  logic [IDX_W-1:0] best_idx_r;
  frame_t           best_frame_r;
  logic             better;

  // Lower count wins; on equal count the older stamp wins; a full tie keeps
  // the earlier frame.
  always_comb begin
    better = ctl.first
          || (rd_frame.freq < best_frame_r.freq)
          || ((rd_frame.freq == best_frame_r.freq) && (rd_frame.stamp < best_frame_r.stamp));
    win_idx   = better ? idx      : best_idx_r;
    win_frame = better ? rd_frame : best_frame_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      best_idx_r   <= win_idx;
      best_frame_r <= win_frame;
    end
  end

endmodule

/* design/lfu_page_replacement.sv */
// Top level of the LFU page replacement block with oldest-stamp tie break.
// Depends on lfu_pkg, lfu_in_if, lfu_out_if and lfu_victim.
//
//  Channel   Direction  Handshake             Payload
//  in_ch     in         valid/ready           page_number
//  out_ch    out        valid/ready           fault, slot, evicted, evicted_page,
//                                             use_count, fault_total
//  cfg_*     in         cfg_we, no wait       cfg_wdata = frames_in_use
//
// One access is handled at a time. A hit on frame j is accepted, reads frames 0 to j
// and emits. A miss reads every occupied frame and then takes a free frame if one
// remains, or else scans the first limit frames for a victim; the frame memory, whose
// one read port delivers one frame per cycle, paces these reads. The ready goes high
// again in the cycle after the emit.
// Reset clears occupancy, the access number and the fault count; the frame memory
// is not cleared, since only occupied frames are ever used.
// A result waiting in the output register does not block the next access from
// being accepted; only the emit of that next access waits for the output to free.
module lfu_page_replacement (
  input  logic                        clk,
  input  logic                        rst_n,
  lfu_in_if.sink                      in_ch,
  lfu_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [lfu_pkg::CFG_W-1:0]   cfg_wdata
);
  import lfu_pkg::*;

  // Control state.
  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    cfg_r;
  logic [CNT_W-1:0]    occupied_r, occupied_nxt;
  logic [STAMP_W-1:0]  access_r, access_nxt;
  logic [FAULT_W-1:0]  fault_cnt_r, fault_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                res_fault_r, res_fault_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                res_evicted_r, res_evicted_nxt;
  logic [PAGE_W-1:0]   res_evpage_r, res_evpage_nxt;
  logic [FREQ_W-1:0]   res_use_r, res_use_nxt;
  logic [FAULT_W-1:0]  res_total_r, res_total_nxt;
  logic                out_fault_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_evicted_r;
  logic [PAGE_W-1:0]   out_evpage_r;
  logic [FREQ_W-1:0]   out_use_r;
  logic [FAULT_W-1:0]  out_total_r;

  // Frame memory: one write port and one registered read port.
  frame_t              mem [FRAMES];
  frame_t              rd_frame_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  frame_t              mem_wd;

  // Scan and lookup helpers.
  logic                in_xfer;
  logic                out_free;
  logic                hit;
  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    idx_inc;
  logic                last_look;
  logic                last_scan;
  logic                has_free;
  scan_ctl_t           scan_ctl;
  logic [IDX_W-1:0]    win_idx;
  frame_t              win_frame;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // A limit of zero acts as one; values above the frame count are clipped.
  always_comb begin
    if (cfg_r == '0) begin
      limit = CNT_W'(1);
    end else if (32'(cfg_r) > 32'(FRAMES)) begin
      limit = CNT_W'(FRAMES);
    end else begin
      limit = CNT_W'(cfg_r);
    end
  end

  assign hit       = (rd_frame_r.page == page_r);
  assign idx_inc   = CNT_W'(idx_r) + CNT_W'(1);
  assign last_look = (idx_inc >= occupied_r);
  assign last_scan = (idx_inc >= limit);
  assign has_free  = (occupied_r < limit);

  assign scan_ctl.step  = (state_r == ST_SCAN);
  assign scan_ctl.first = (idx_r == '0);

  lfu_victim u_victim (
    .clk       (clk),
    .ctl       (scan_ctl),
    .idx       (idx_r),
    .rd_frame  (rd_frame_r),
    .win_idx   (win_idx),
    .win_frame (win_frame)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (occupied_r == '0) ? ST_MISS : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (hit) begin
          state_nxt = ST_EMIT;
        end else if (last_look) begin
          state_nxt = ST_MISS;
        end
      end
      ST_MISS: begin
        state_nxt = has_free ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (last_scan) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the controller. Memory writes only occur once per
  // access, before the emit, and the emit state always lies between that write and
  // the first read of the next access, so no read ever overlaps a pending write.
  always_comb begin
    rd_addr         = '0;
    mem_we          = 1'b0;
    mem_wa          = idx_r;
    mem_wd          = '{page: page_r, freq: FREQ_W'(1), stamp: access_r};
    idx_nxt         = idx_r;
    page_nxt        = page_r;
    occupied_nxt    = occupied_r;
    access_nxt      = access_r;
    fault_cnt_nxt   = fault_cnt_r;
    res_fault_nxt   = res_fault_r;
    res_slot_nxt    = res_slot_r;
    res_evicted_nxt = res_evicted_r;
    res_evpage_nxt  = res_evpage_r;
    res_use_nxt     = res_use_r;
    res_total_nxt   = res_total_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_xfer) begin
          page_nxt = in_ch.page_number;
          if (access_r != '1) begin
            access_nxt = access_r + STAMP_W'(1);
          end
        end
      end
      ST_LOOKUP: begin
        rd_addr = idx_r + IDX_W'(1);
        idx_nxt = idx_r + IDX_W'(1);
        if (hit) begin
          mem_we       = 1'b1;
          mem_wa       = idx_r;
          mem_wd.page  = rd_frame_r.page;
          mem_wd.freq  = (rd_frame_r.freq == '1) ? rd_frame_r.freq
                                                 : rd_frame_r.freq + FREQ_W'(1);
          mem_wd.stamp = access_r;
          res_fault_nxt   = 1'b0;
          res_slot_nxt    = SLOT_W'(idx_r);
          res_evicted_nxt = 1'b0;
          res_evpage_nxt  = '0;
          res_use_nxt     = mem_wd.freq;
          res_total_nxt   = fault_cnt_r;
        end
      end
      ST_MISS: begin
        rd_addr = '0;
        idx_nxt = '0;
        if (fault_cnt_r != '1) begin
          fault_cnt_nxt = fault_cnt_r + FAULT_W'(1);
        end
        res_fault_nxt = 1'b1;
        res_use_nxt   = FREQ_W'(1);
        res_total_nxt = fault_cnt_nxt;
        if (has_free) begin
          mem_we          = 1'b1;
          mem_wa          = IDX_W'(occupied_r);
          occupied_nxt    = occupied_r + CNT_W'(1);
          res_slot_nxt    = SLOT_W'(occupied_r);
          res_evicted_nxt = 1'b0;
          res_evpage_nxt  = '0;
        end
      end
      ST_SCAN: begin
        rd_addr = idx_r + IDX_W'(1);
        idx_nxt = idx_r + IDX_W'(1);
        if (last_scan) begin
          mem_we          = 1'b1;
          mem_wa          = win_idx;
          res_slot_nxt    = SLOT_W'(win_idx);
          res_evicted_nxt = 1'b1;
          res_evpage_nxt  = win_frame.page;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_RESET;
      occupied_r  <= '0;
      access_r    <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occupied_r  <= occupied_nxt;
      access_r    <= access_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    page_r        <= page_nxt;
    idx_r         <= idx_nxt;
    res_fault_r   <= res_fault_nxt;
    res_slot_r    <= res_slot_nxt;
    res_evicted_r <= res_evicted_nxt;
    res_evpage_r  <= res_evpage_nxt;
    res_use_r     <= res_use_nxt;
    res_total_r   <= res_total_nxt;
    if (state_r == ST_EMIT && out_free) begin
      out_fault_r   <= res_fault_r;
      out_slot_r    <= res_slot_r;
      out_evicted_r <= res_evicted_r;
      out_evpage_r  <= res_evpage_r;
      out_use_r     <= res_use_r;
      out_total_r   <= res_total_r;
    end
  end

  // Frame memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_frame_r <= mem[rd_addr];
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.fault        = out_fault_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.evicted      = out_evicted_r;
  assign out_ch.evicted_page = out_evpage_r;
  assign out_ch.use_count    = out_use_r;
  assign out_ch.fault_total  = out_total_r;

  // Occupancy never grows past the frame count.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occupied_r) <= 32'(FRAMES))
    else $error("occupancy exceeds the frame count");

  // The fault count only moves in the miss state.
  a_fault_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r != ST_MISS) |=> (fault_cnt_r == $past(fault_cnt_r)))
    else $error("fault count changed outside a miss");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.fault) |-> !out_ch.evicted)
    else $error("eviction reported on a hit");

  // An emit with a free output register presents the result next cycle.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("emit did not load the output register");

  // An accepted access always leaves the idle state.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_LOOKUP || state_r == ST_MISS))
    else $error("accepted access did not start a lookup");

endmodule
